// ===== rtl/b64d_pkg.sv =====
// Shared types, constants and the alphabet lookup for the Base64 decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic [7:0] ChCr  = 8'h0D;
   localparam logic [7:0] ChLf  = 8'h0A;
   localparam logic [7:0] ChPad = 8'h3D;

   localparam logic ActChar = 1'b0;
   localparam logic ActEnd  = 1'b1;

   localparam logic [15:0] CapacityReset = 16'hFFFF;

   // One unit of work handed from front to back: a status or one to three bytes.
   typedef struct packed {
      logic            is_byte;
      logic [1:0]      n_bytes;
      logic [2:0][7:0] data;
      logic [15:0]     count;   // bytes: total before this quartet; status: reported count
      logic            error;
   } b64d_job_type;

   typedef struct packed {
      logic  valid;
      logic  [6:0] sextet;   // bit 6 set when the character is not in the alphabet
   } b64d_class_type;

   function automatic b64d_class_type classify(input logic [7:0] c);
      b64d_class_type r;
      r.valid  = 1'b1;
      r.sextet = 7'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         r.sextet = {1'b0, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         r.sextet = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
         r.sextet = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r.sextet = 7'd62;
      end else if (c == 8'h2F) begin
         r.sextet = 7'd63;
      end else begin
         r.valid  = 1'b0;
         r.sextet = 7'h40;
      end
      return r;
   endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// Front end: accepts characters, tracks quartet and padding state, checks
// capacity and issues jobs. Holds the capacity register. Uses b64d_pkg.
module b64d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data,
   input  logic                 q_full,
   output logic                 push,
   output b64d_pkg::b64d_job_type push_job
);
   import b64d_pkg::*;

   logic [15:0]       cap_ff;
   logic [2:0][5:0]   hold_ff, hold_in;
   logic [1:0]        pos_ff, pos_in;
   logic [1:0]        pads_ff, pads_in;
   logic              pad_seen_ff, pad_seen_in;
   logic              third_pad_ff, third_pad_in;
   logic              err_ff, err_in;
   logic [15:0]       total_ff, total_in;

   b64d_class_type    cls;
   logic              accept, is_pad, is_crlf, err_now;
   logic [5:0]        s;
   logic [1:0]        n;
   logic [16:0]       sum;

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cls     = classify(req_tdata);
      is_pad  = (req_tdata == ChPad);
      is_crlf = (req_tdata == ChCr) || (req_tdata == ChLf);
      s       = is_pad ? 6'd0 : cls.sextet[5:0];
      if (third_pad_ff)
         n = 2'd1;
      else if (is_pad)
         n = 2'd2;
      else
         n = 2'd3;
      sum = {1'b0, total_ff} + {15'd0, n};

      hold_in      = hold_ff;
      pos_in       = pos_ff;
      pads_in      = pads_ff;
      pad_seen_in  = pad_seen_ff;
      third_pad_in = third_pad_ff;
      err_in       = err_ff;
      total_in     = total_ff;
      push         = 1'b0;
      push_job     = '0;
      err_now      = err_ff || (pos_ff != 2'd0);

      if (accept) begin
         if (req_tuser == ActEnd) begin
            push             = 1'b1;
            push_job.is_byte = 1'b0;
            push_job.error   = err_now;
            push_job.count   = err_now ? 16'd0 : total_ff;
            push_job.n_bytes = 2'd1;
            hold_in      = '0;
            pos_in       = 2'd0;
            pads_in      = 2'd0;
            pad_seen_in  = 1'b0;
            third_pad_in = 1'b0;
            err_in       = 1'b0;
            total_in     = 16'd0;
         end else if (is_crlf || err_ff) begin
            // absorbed
         end else if (is_pad && (pos_ff < 2'd2 || pads_ff >= 2'd2)) begin
            err_in = 1'b1;
         end else if (!is_pad && (pad_seen_ff || !cls.valid)) begin
            err_in = 1'b1;
         end else begin
            if (is_pad) begin
               pads_in     = pads_ff + 2'd1;
               pad_seen_in = 1'b1;
            end
            if (pos_ff != 2'd3) begin
               if (pos_ff == 2'd0) hold_in[0] = s;
               if (pos_ff == 2'd1) hold_in[1] = s;
               if (pos_ff == 2'd2) begin
                  hold_in[2]   = s;
                  third_pad_in = is_pad;
               end
               pos_in = pos_ff + 2'd1;
            end else begin
               pos_in       = 2'd0;
               third_pad_in = 1'b0;
               if (sum > {1'b0, cap_ff}) begin
                  err_in = 1'b1;
               end else begin
                  total_in         = sum[15:0];
                  push             = 1'b1;
                  push_job.is_byte = 1'b1;
                  push_job.n_bytes = n;
                  push_job.count   = total_ff;
                  push_job.error   = 1'b0;
                  push_job.data[0] = {hold_ff[0], hold_ff[1][5:4]};
                  push_job.data[1] = {hold_ff[1][3:0], hold_ff[2][5:2]};
                  push_job.data[2] = {hold_ff[2][1:0], s};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_in_reg: hold_ff <= hold_in;
      if (reset) begin
         cap_ff       <= CapacityReset;
         pos_ff       <= 2'd0;
         pads_ff      <= 2'd0;
         pad_seen_ff  <= 1'b0;
         third_pad_ff <= 1'b0;
         err_ff       <= 1'b0;
         total_ff     <= 16'd0;
      end else begin
         if (csr_valid && csr_ready) cap_ff <= csr_data;
         pos_ff       <= pos_in;
         pads_ff      <= pads_in;
         pad_seen_ff  <= pad_seen_in;
         third_pad_ff <= third_pad_in;
         err_ff       <= err_in;
         total_ff     <= total_in;
      end
   end

endmodule

// ===== rtl/b64d_queue.sv =====
// Short job queue between front and back ends.
// Uses b64d_pkg for the job type and depth.
module b64d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64d_pkg::b64d_job_type push_job,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output b64d_pkg::b64d_job_type head_job
);
   import b64d_pkg::*;

   b64d_job_type       mem_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ff, rd_ff;
   logic [QCntW-1:0]   cnt_ff;
   logic               do_pop;

   assign full       = (cnt_ff == QCntW'(QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)   wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (push && !do_pop)
            cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !push)
            cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: expands each job into result items behind an output register.
// Uses b64d_pkg for the job type.
module b64d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  b64d_pkg::b64d_job_type head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import b64d_pkg::*;

   logic        valid_ff;
   logic [31:0] data_ff, data_in;
   logic        user_ff, user_in;
   logic        last_ff, last_in;
   logic [1:0]  idx_ff, idx_in;
   logic        load;
   logic [15:0] cnt;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;
   assign load       = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      cnt     = head_job.count + {14'd0, idx_ff} + 16'd1;
      user_in = head_job.is_byte;
      last_in = !head_job.is_byte || (idx_ff == head_job.n_bytes - 2'd1);
      if (head_job.is_byte)
         data_in = {7'd0, cnt, 1'b0, head_job.data[idx_ff]};
      else
         data_in = {7'd0, head_job.count, head_job.error, 8'd0};
      pop    = load && last_in;
      idx_in = idx_ff;
      if (load) idx_in = last_in ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (load)
            valid_ff <= 1'b1;
         else if (rsp_tready)
            valid_ff <= 1'b0;
      end
   end

endmodule

// ===== rtl/base64_decoder_checked.sv =====
// Top level of the checked Base64 decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//  channel | direction | tdata / data                      | tuser        | tlast
//  req_    | in        | [7:0] char_code                   | [0] action   | -
//  rsp_    | out       | [7:0] byte_value [8] error        | [0] is_byte  | last
//          |           | [24:9] byte_count [31:25] zero    |              |
//  csr_    | in        | [15:0] dst_capacity               | -            | -
//
// One character per cycle is accepted unless the job queue is full; a completed quartet
// is queued as one job. The back end emits one result per cycle unless the output stalls,
// so a quartet yields one to three results there and an end item one; the four-entry
// job queue absorbs the difference. Reset clears the control state, not the data
// registers, and sets the capacity to 65535. Output stalls back up into the job queue.
module base64_decoder_checked (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] byte_value, [8] error, [24:9] byte_count
   output logic        rsp_tuser,   // [0] is_byte
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import b64d_pkg::*;

   logic         push, pop, q_full, head_valid;
   b64d_job_type push_job, head_job;

   b64d_front u_front (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .csr_valid, .csr_ready, .csr_data,
      .q_full, .push, .push_job
   );

   b64d_queue u_queue (
      .clock, .reset,
      .push, .push_job, .pop,
      .full(q_full), .head_valid, .head_job
   );

   b64d_back u_back (
      .clock, .reset,
      .head_valid, .head_job, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

// ===== rtl/b64d_checker.sv =====
// Port-level checks for the Base64 decoder, bound to the top level.
// Depends only on the ports of base64_decoder_checked.
module b64d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !reset |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item dropped or changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status item not marked last");

   a_byte_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[8])
      else $error("data byte carries error");

   a_err_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[8] |-> rsp_tdata[24:9] == 16'd0)
      else $error("error status with non-zero count");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:25] == 7'd0 && (rsp_tuser || rsp_tdata[7:0] == 8'd0))
      else $error("unused result bits not zero");

endmodule

bind base64_decoder_checked b64d_checker u_b64d_checker (.*);

// ===== bench/base64_decoder_checked_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for base64_decoder_checked: directed and random text streams
// against a cycle-free Base64 decode predictor, with sender and receiver stalls.
// Depends on b64d_pkg and the RTL of base64_decoder_checked.
module base64_decoder_checked_tb;
   import b64d_pkg::*;

   typedef struct packed {
      logic        is_byte;
      logic [7:0]  value;
      logic        err;
      logic [15:0] count;
      logic        last;
   } decoded_item_type;

   class b64_decode_scoreboard;
      logic [15:0]      capacity;
      logic [5:0]       held [3];
      logic [1:0]       qpos;
      logic [1:0]       pads;
      logic             pad_seen;
      logic             third_pad;
      logic             err;
      logic [16:0]      total;
      decoded_item_type awaited [$];
      int               fails;

      function new();
         capacity = CapacityReset;
         fails    = 0;
         clear();
      endfunction

      function void clear();
         held      = '{default: 6'd0};
         qpos      = 2'd0;
         pads      = 2'd0;
         pad_seen  = 1'b0;
         third_pad = 1'b0;
         err       = 1'b0;
         total     = 17'd0;
      endfunction

      function int sextet_value(logic [7:0] c);
         if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
         if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
         if (c == 8'h2B) return 62;
         if (c == 8'h2F) return 63;
         return -1;
      endfunction

      function void note_item(logic act, logic [7:0] code);
         decoded_item_type r;
         logic [7:0]       b [3];
         logic [5:0]       s;
         logic             is_pad;
         int               v;
         int               n;
         if (act == ActEnd) begin
            r.is_byte = 1'b0;
            r.value   = 8'd0;
            r.err     = err | (qpos != 2'd0);
            r.count   = r.err ? 16'd0 : (total > 17'hFFFF ? 16'hFFFF : total[15:0]);
            r.last    = 1'b1;
            awaited.push_back(r);
            clear();
            return;
         end
         if (code == ChCr || code == ChLf || err) return;
         is_pad = (code == ChPad);
         if (is_pad) begin
            if (qpos < 2'd2 || pads >= 2'd2) begin
               err = 1'b1;
               return;
            end
            pads++;
            pad_seen = 1'b1;
            s = 6'd0;
         end else begin
            v = sextet_value(code);
            if (pad_seen || v < 0) begin
               err = 1'b1;
               return;
            end
            s = 6'(v);
         end
         if (qpos < 2'd3) begin
            held[qpos] = s;
            if (qpos == 2'd2) third_pad = is_pad;
            qpos++;
            return;
         end
         qpos = 2'd0;
         b[0] = {held[0], held[1][5:4]};
         n = 1;
         if (!third_pad) begin
            b[n] = {held[1][3:0], held[2][5:2]};
            n++;
         end
         if (!is_pad) begin
            b[n] = {held[2][1:0], s};
            n++;
         end
         third_pad = 1'b0;
         if (32'(total) + n > 32'(capacity)) begin
            err = 1'b1;
            return;
         end
         for (int i = 0; i < n; i++) begin
            if (total != 17'h1FFFF) total++;
            r.is_byte = 1'b1;
            r.value   = b[i];
            r.err     = 1'b0;
            r.count   = total > 17'hFFFF ? 16'hFFFF : total[15:0];
            r.last    = (i == n - 1);
            awaited.push_back(r);
         end
      endfunction

      function void compare_field(string label, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            fails++;
         end
      endfunction

      function void check_result(logic is_byte, logic [7:0] value, logic e,
                                 logic [15:0] count, logic last);
         decoded_item_type w;
         if (awaited.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, %s",
                     $time, "actual");
            $display("   %0b/0x%0h/%0b/%0d/%0b", is_byte, value, e, count, last);
            fails++;
            return;
         end
         w = awaited.pop_front();
         compare_field("is_byte", w.is_byte, is_byte);
         compare_field("byte_value", w.value, value);
         compare_field("error", w.err, e);
         compare_field("byte_count", w.count, count);
         compare_field("last", w.last, last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   b64_decode_scoreboard tracker = new();
   int send_idle_pct;
   int recv_stall_pct;
   int counted;
   int quiet_cycles;

   localparam int QuietLimit = 3000;

   base64_decoder_checked uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[8],
                              rsp_tdata[24:9], rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("base64_decoder_checked regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] sextet_char(logic [5:0] v);
      if (v < 6'd26) return 8'h41 + 8'(v);
      if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
      if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
      return (v == 6'd62) ? 8'h2B : 8'h2F;
   endfunction

   task automatic send_item(input logic act, input logic [7:0] code);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      tracker.note_item(act, code);
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++) send_item(ActChar, s[i]);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] cap);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      tracker.capacity = cap;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed strings, some broken ones, some plain noise.
   task automatic send_random_string();
      logic [7:0]  raw [$];
      logic [7:0]  text [$];
      logic [23:0] grp;
      int          nbytes;
      int          take;
      int          mode;
      nbytes = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      repeat (nbytes) raw.push_back(8'($urandom_range(255)));
      for (int i = 0; i < nbytes; i += 3) begin
         take = (nbytes - i > 3) ? 3 : nbytes - i;
         grp  = {raw[i], take > 1 ? raw[i + 1] : 8'd0, take > 2 ? raw[i + 2] : 8'd0};
         text.push_back(sextet_char(grp[23:18]));
         text.push_back(sextet_char(grp[17:12]));
         text.push_back(take > 1 ? sextet_char(grp[11:6]) : ChPad);
         text.push_back(take > 2 ? sextet_char(grp[5:0]) : ChPad);
      end
      mode = $urandom_range(99);
      if (mode >= 85) begin
         text.delete();
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
      end else if (mode >= 65) begin
         case ($urandom_range(3))
            0: begin
               if (text.size() > 0)
                  text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
               else
                  text.push_back(8'($urandom_range(255)));
            end
            1: begin
               if (text.size() > 0) void'(text.pop_back());
            end
            2: begin
               text.push_back(ChPad);
            end
            default: begin
               if (text.size() > 0) text[$urandom_range(text.size() - 1)] = ChPad;
               else text.push_back(ChPad);
            end
         endcase
      end
      foreach (text[i]) begin
         if ($urandom_range(9) == 0) begin
            send_item(ActChar, $urandom_range(1) ? ChCr : ChLf);
            counted++;
         end
         send_item(ActChar, text[i]);
         counted++;
      end
      send_item(ActEnd, 8'($urandom_range(255)));
      counted++;
   endtask

   int idle_tbl  [4] = '{0, 74, 0, 11};
   int stall_tbl [4] = '{0, 0, 74, 11};

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'd0;
      req_tuser      = ActChar;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = 16'd0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      counted        = 0;
      quiet_cycles   = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full quartet, line breaks inside a quartet, one and two pads
      send_chars("/+Az");
      send_item(ActChar, ChCr);
      send_chars("Zm");
      send_item(ActChar, ChLf);
      send_chars("8=");
      send_item(ActEnd, 8'hFF);
      send_chars("QQ==");
      send_item(ActEnd, 8'h00);
      // misplaced pad, data after pad, foreign codes, short tail
      send_chars("=");
      send_item(ActEnd, 8'h00);
      send_chars("QU=A");
      send_item(ActEnd, 8'h00);
      send_item(ActChar, 8'h00);
      send_item(ActChar, 8'hFF);
      send_item(ActEnd, 8'h00);
      send_chars("QU");
      send_item(ActEnd, 8'h00);
      // zero capacity
      wait_idle();
      write_capacity(16'h0000);
      send_chars("QQ==");
      send_item(ActEnd, 8'h00);

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         case (p)
            0, 3:    write_capacity(16'hFFFF);
            default: write_capacity(16'($urandom_range(2, 24)));
         endcase
         send_idle_pct  = idle_tbl[p];
         recv_stall_pct = stall_tbl[p];
         counted        = 0;
         while (counted < 90) send_random_string();
      end

      wait_idle();
      if (tracker.fails == 0) begin
         $display("base64_decoder_checked regression: pass");
      end else begin
         $display("base64_decoder_checked regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_checked.sv
rtl/b64d_checker.sv
bench/base64_decoder_checked_tb.sv
